[rtl/lebd_pkg.sv]
package lebd_pkg;

   typedef enum logic [1:0] {
      KIND_U32 = 2'd0,
      KIND_S32 = 2'd1,
      KIND_U64 = 2'd2,
      KIND_S64 = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_LENGTH = 2'd1,
      STATUS_SIGN   = 2'd2
   } status_type;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [3:0] NARROW_LIMIT = 4'd5;
   localparam logic [3:0] WIDE_LIMIT   = 4'd10;

   localparam logic [7:0] NARROW_TOP_MASK = 8'hf0;
   localparam logic [7:0] NARROW_TOP_ONES = 8'h70;
   localparam logic [7:0] WIDE_TOP_MASK   = 8'hfe;
   localparam logic [7:0] WIDE_TOP_ONES   = 8'h7e;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [3:0] pos;
      kind_type   kind;
      logic       last;
      status_type status;
   } entry_type;

   function automatic logic kind_is_wide(kind_type kind);
      return (kind == KIND_U64) || (kind == KIND_S64);
   endfunction

   function automatic logic kind_is_signed(kind_type kind);
      return (kind == KIND_S32) || (kind == KIND_S64);
   endfunction

endpackage

[rtl/lebd_front.sv]
module lebd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // data_byte[7:0]
   input  logic [1:0]          req_tuser,   // action[1:0]
   input  logic                req_tlast,
   input  logic                q_ready,
   output logic                q_push,
   output lebd_pkg::entry_type q_entry
);

   logic [3:0]         bytes_seen_ff, bytes_seen_in;
   lebd_pkg::kind_type kind_ff, kind_in;
   lebd_pkg::kind_type kind;
   logic [3:0]         limit;
   logic [3:0]         count;
   logic               wide;
   logic               last;
   lebd_pkg::status_type status;
   logic [7:0]         b;

   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;
   assign b          = req_tdata;

   always_comb begin
      kind   = (bytes_seen_ff == 4'd0) ? lebd_pkg::kind_type'(req_tuser) : kind_ff;
      wide   = lebd_pkg::kind_is_wide(kind);
      limit  = wide ? lebd_pkg::WIDE_LIMIT : lebd_pkg::NARROW_LIMIT;
      count  = bytes_seen_ff + 4'd1;
      last   = 1'b1;
      status = lebd_pkg::STATUS_OK;
      if (b[7]) begin
         if (count >= limit || req_tlast) begin
            status = lebd_pkg::STATUS_LENGTH;
         end else begin
            last = 1'b0;
         end
      end else if (lebd_pkg::kind_is_signed(kind) && count == limit) begin
         if (!wide) begin
            if (b[3] ? ((b & lebd_pkg::NARROW_TOP_MASK) != lebd_pkg::NARROW_TOP_ONES)
                     : ((b & lebd_pkg::NARROW_TOP_MASK) != 8'h00)) begin
               status = lebd_pkg::STATUS_SIGN;
            end
         end else begin
            if (b[0] ? ((b & lebd_pkg::WIDE_TOP_MASK) != lebd_pkg::WIDE_TOP_ONES)
                     : ((b & lebd_pkg::WIDE_TOP_MASK) != 8'h00)) begin
               status = lebd_pkg::STATUS_SIGN;
            end
         end
      end
   end

   always_comb begin
      q_entry.data_byte = b;
      q_entry.pos       = bytes_seen_ff;
      q_entry.kind      = kind;
      q_entry.last      = last;
      q_entry.status    = status;
   end

   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      kind_in       = kind_ff;
      if (q_push) begin
         bytes_seen_in = last ? 4'd0 : count;
         kind_in       = kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= 4'd0;
         kind_ff       <= lebd_pkg::KIND_U32;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         kind_ff       <= kind_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      bytes_seen_ff < lebd_pkg::WIDE_LIMIT)
      else $error("byte position ran past the wide limit");

   assert property (@(posedge clock) disable iff (reset)
      (bytes_seen_ff != 4'd0 && !lebd_pkg::kind_is_wide(kind_ff))
         |-> bytes_seen_ff < lebd_pkg::NARROW_LIMIT)
      else $error("byte position ran past the narrow limit");

   assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_entry.last) |=> bytes_seen_ff == $past(bytes_seen_ff) + 4'd1)
      else $error("byte position did not advance on a continued number");

endmodule

[rtl/lebd_fifo.sv]
module lebd_fifo #(
   parameter int DEPTH = lebd_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lebd_pkg::entry_type push_entry,
   output logic                push_ready,
   input  logic                pop,
   output logic                pop_valid,
   output lebd_pkg::entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lebd_pkg::entry_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count exceeds depth");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty queue");

   assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("push into full queue");

endmodule

[rtl/lebd_back.sv]
module lebd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  lebd_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [71:0]         rsp_tdata,   // value[63:0], byte_count[67:64], zero pad
   output logic [1:0]          rsp_tuser    // status[1:0]
);

   logic [63:0]          acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [63:0]          value_ff, value_in;
   logic [3:0]           count_ff, count_in;
   lebd_pkg::status_type status_ff, status_in;

   logic [6:0]  shamt_wide;
   logic [63:0] acc_sum;
   logic [3:0]  count;
   logic [6:0]  sbit_wide;
   logic [5:0]  sbit;
   logic [63:0] base;
   logic [63:0] value;
   logic        load;

   assign q_pop = q_valid && (!q_entry.last || !rsp_valid_ff || rsp_tready);
   assign load  = q_pop && q_entry.last;

   always_comb begin
      shamt_wide = {q_entry.pos, 3'b000} - {3'b000, q_entry.pos};
      acc_sum    = acc_ff | (64'(q_entry.data_byte[6:0]) << shamt_wide[5:0]);
      count      = q_entry.pos + 4'd1;
      sbit_wide  = {count, 3'b000} - {3'b000, count} - 7'd1;
      if (lebd_pkg::kind_is_wide(q_entry.kind)) begin
         base = acc_sum;
         sbit = (sbit_wide > 7'd63) ? 6'd63 : sbit_wide[5:0];
      end else begin
         base = {32'h0, acc_sum[31:0]};
         sbit = (sbit_wide > 7'd31) ? 6'd31 : sbit_wide[5:0];
      end
      value = base;
      if (lebd_pkg::kind_is_signed(q_entry.kind) && base[sbit]) begin
         value = base | (~64'h0 << sbit);
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      value_in     = value_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      if (q_pop) begin
         acc_in = q_entry.last ? 64'h0 : acc_sum;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         status_in    = q_entry.status;
         if (q_entry.status == lebd_pkg::STATUS_OK) begin
            value_in = value;
            count_in = count;
         end else begin
            value_in = 64'h0;
            count_in = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 64'h0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      count_ff  <= count_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, count_ff, value_ff};
   assign rsp_tuser  = status_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != lebd_pkg::STATUS_OK) |-> (value_ff == 64'h0 && count_ff == 4'd0))
      else $error("error result carries a value or byte count");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == lebd_pkg::STATUS_OK)
         |-> (count_ff != 4'd0 && count_ff <= lebd_pkg::WIDE_LIMIT))
      else $error("good result byte count out of range");

   assert property (@(posedge clock) disable iff (reset)
      load |=> acc_ff == 64'h0)
      else $error("accumulator not cleared after a result");

endmodule

[rtl/bounded_leb128_stream_decoder.sv]
// LEB128 stream decoder.
// req_* carries one encoded byte per item: tdata is the byte, tuser the
// number kind (0 u32, 1 s32, 2 u64, 3 s64, taken from the first byte of
// each number) and tlast marks the last byte available in the buffer.
// rsp_* carries one item per finished number: tdata holds the 64-bit value
// and the byte count, tuser the status (0 ok, 1 truncated or too long,
// 2 bad sign extension on the final byte). Errors give value 0, count 0.
// A front stage tags each byte with its position, kind and end/error
// status and pushes it into a short queue; a back stage ORs the 7-bit
// group into the accumulator and loads the output register on the last
// byte of a number.
// Results are registered: a final byte passes the queue, then loads the output
// register. Throughput: one byte per cycle, set by the single accumulate step
// of the back stage, while no finished result is held by a low rsp_tready.
// Reset clears the byte position, the kind, the accumulator, the queue and
// the output valid. While rsp_tready is low the result holds; the queue
// keeps taking bytes until it fills, then req_tready drops.
module bounded_leb128_stream_decoder #(
   parameter int QUEUE_DEPTH = lebd_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic [1:0]  req_tuser,   // action[1:0]
   input  logic        req_tlast,   // buffer_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // value[63:0], byte_count[67:64], zero pad
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   logic                q_push;
   logic                q_push_ready;
   lebd_pkg::entry_type q_push_entry;
   logic                q_pop;
   logic                q_pop_valid;
   lebd_pkg::entry_type q_pop_entry;

   lebd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_ready    (q_push_ready),
      .q_push     (q_push),
      .q_entry    (q_push_entry)
   );

   lebd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .push_ready (q_push_ready),
      .pop        (q_pop),
      .pop_valid  (q_pop_valid),
      .pop_entry  (q_pop_entry)
   );

   lebd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_pop_valid),
      .q_entry    (q_pop_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[test/bounded_leb128_stream_decoder_tb.sv]
module bounded_leb128_stream_decoder_tb;

   localparam int CYCLE_LIMIT = 100000;

   typedef struct {
      logic [63:0]          value;
      logic [3:0]           count;
      lebd_pkg::status_type status;
   } decoded_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // data_byte[7:0]
   logic [1:0]  req_tuser;   // action[1:0]
   logic        req_tlast;   // buffer_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;   // value[63:0], byte_count[67:64], zero pad
   logic [1:0]  rsp_tuser;   // status[1:0]

   // decoder state mirror
   logic [63:0]        group_acc = '0;
   logic [3:0]         groups_seen = '0;
   lebd_pkg::kind_type number_kind = lebd_pkg::KIND_U32;

   decoded_type pending_numbers[$];

   bit gaps_on = 1'b1;
   bit stalls_on = 1'b1;
   int hold_req = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int bytes_sent = 0;
   int ok_count = 0;
   int length_err_count = 0;
   int sign_err_count = 0;
   int errors = 0;

   bounded_leb128_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d numbers outstanding", cycle_count,
                  pending_numbers.size());
         $display("bounded_leb128_stream_decoder test failed");
         $finish;
      end
   end

   function automatic logic [63:0] widen_signed(input logic [63:0] v, input int msb);
      if (msb < 63 && v[msb]) begin
         v |= ~64'd0 << (msb + 1);
      end
      return v;
   endfunction

   // advance the mirror by one byte; return 1 when the byte finishes a number
   function automatic bit decode_step(input lebd_pkg::kind_type kind, input logic [7:0] b,
                                      input logic last, output decoded_type res);
      logic        wide;
      logic        sgn;
      logic [3:0]  limit;
      logic [3:0]  count;
      logic [63:0] low;
      res.value = '0;
      res.count = '0;
      res.status = lebd_pkg::STATUS_OK;
      if (groups_seen == 0) begin
         number_kind = kind;
      end
      wide = number_kind[1];
      sgn = number_kind[0];
      limit = wide ? lebd_pkg::WIDE_LIMIT : lebd_pkg::NARROW_LIMIT;
      group_acc |= {57'd0, b[6:0]} << (7 * groups_seen);
      count = groups_seen + 4'd1;
      if (b[7]) begin
         if (count < limit && !last) begin
            groups_seen = count;
            return 1'b0;
         end
         res.status = lebd_pkg::STATUS_LENGTH;
      end else if (!wide) begin
         low = {32'd0, group_acc[31:0]};
         if (!sgn) begin
            res.value = low;
         end else if (count == lebd_pkg::NARROW_LIMIT) begin
            if ((b & lebd_pkg::NARROW_TOP_MASK)
                != (b[3] ? lebd_pkg::NARROW_TOP_ONES : 8'h00)) begin
               res.status = lebd_pkg::STATUS_SIGN;
            end else begin
               res.value = widen_signed(low, 31);
            end
         end else begin
            res.value = widen_signed(low, 7 * count - 1);
         end
      end else begin
         if (!sgn) begin
            res.value = group_acc;
         end else if (count == lebd_pkg::WIDE_LIMIT) begin
            if ((b & lebd_pkg::WIDE_TOP_MASK)
                != (b[0] ? lebd_pkg::WIDE_TOP_ONES : 8'h00)) begin
               res.status = lebd_pkg::STATUS_SIGN;
            end else begin
               res.value = group_acc;
            end
         end else begin
            res.value = widen_signed(group_acc, 7 * count - 1);
         end
      end
      if (res.status == lebd_pkg::STATUS_OK) begin
         res.count = count;
      end else begin
         res.value = '0;
      end
      group_acc = '0;
      groups_seen = '0;
      return 1'b1;
   endfunction

   task automatic send_byte(input lebd_pkg::kind_type kind, input logic [7:0] b,
                            input logic last);
      decoded_type res;
      req_tvalid = 1'b0;
      while (gaps_on && $urandom_range(99) < 28) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = b;
      req_tuser = kind;
      req_tlast = last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (decode_step(kind, b, last, res)) begin
         pending_numbers.push_back(res);
      end
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // one number: mostly well formed, some truncated, too long or plain noise
   task automatic send_random_number();
      lebd_pkg::kind_type kind;
      int                 limit;
      int                 len;
      int                 pick;
      logic               s;
      logic [7:0]         b;
      kind = lebd_pkg::kind_type'($urandom_range(3));
      limit = int'(kind[1] ? lebd_pkg::WIDE_LIMIT : lebd_pkg::NARROW_LIMIT);
      len = $urandom_range(1) ? $urandom_range(3, 1) : $urandom_range(limit, 1);
      pick = $urandom_range(99);
      if (pick < 10) begin
         repeat ($urandom_range(4, 1)) begin
            send_byte(lebd_pkg::kind_type'($urandom_range(3)), 8'($urandom_range(255)),
                      $urandom_range(7) == 0);
         end
      end else if (pick < 16) begin
         for (int i = 1; i <= limit; i++) begin
            send_byte(i == 1 ? kind : lebd_pkg::kind_type'($urandom_range(3)),
                      {1'b1, 7'($urandom_range(127))}, 1'b0);
         end
      end else if (pick < 24) begin
         for (int i = 1; i <= len; i++) begin
            send_byte(i == 1 ? kind : lebd_pkg::kind_type'($urandom_range(3)),
                      {1'b1, 7'($urandom_range(127))}, i == len);
         end
      end else begin
         for (int i = 1; i <= len; i++) begin
            s = 1'($urandom_range(1));
            if (i < len) begin
               b = {1'b1, 7'($urandom_range(127))};
            end else if (len == limit && $urandom_range(2) != 0) begin
               // favor a proper sign extension on the full-length tail
               b = kind[1] ? {1'b0, {7{s}}} : {1'b0, {4{s}}, 3'($urandom_range(7))};
            end else begin
               b = {1'b0, 7'($urandom_range(127))};
            end
            send_byte(i == 1 ? kind : lebd_pkg::kind_type'($urandom_range(3)), b,
                      i == len && $urandom_range(9) == 0);
         end
      end
   endtask

   always @(negedge clock) begin
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left != 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         rsp_tready = !(stalls_on && $urandom_range(99) < 28);
      end
   end

   always @(posedge clock) begin
      decoded_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_numbers.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, value %h count %0d status %0d",
                     $time, rsp_tdata[63:0], rsp_tdata[67:64], rsp_tuser);
         end else begin
            want = pending_numbers.pop_front();
            case (want.status)
               lebd_pkg::STATUS_OK:     ok_count++;
               lebd_pkg::STATUS_LENGTH: length_err_count++;
               default:                 sign_err_count++;
            endcase
            if (rsp_tdata[63:0] !== want.value) begin
               errors++;
               $display("%0t: value expected %h actual %h", $time, want.value,
                        rsp_tdata[63:0]);
            end
            if (rsp_tdata[67:64] !== want.count) begin
               errors++;
               $display("%0t: byte_count expected %0d actual %0d", $time, want.count,
                        rsp_tdata[67:64]);
            end
            if (rsp_tuser !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_tuser);
            end
         end
      end
   end

   task automatic test_short_numbers();
      send_byte(lebd_pkg::KIND_U32, 8'h00, 1'b0);
      send_byte(lebd_pkg::KIND_S32, 8'h7f, 1'b0);
      send_byte(lebd_pkg::KIND_S64, 8'h40, 1'b0);
      send_byte(lebd_pkg::KIND_U64, 8'h05, 1'b1);
      send_byte(lebd_pkg::KIND_S32, 8'h80, 1'b1);
   endtask

   task automatic test_narrow_limits();
      send_byte(lebd_pkg::KIND_U32, 8'hff, 1'b0);
      repeat (3) send_byte(lebd_pkg::KIND_S64, 8'hff, 1'b0);
      send_byte(lebd_pkg::KIND_S64, 8'h7f, 1'b0);
      send_byte(lebd_pkg::KIND_S32, 8'h80, 1'b0);
      repeat (3) send_byte(lebd_pkg::KIND_U32, 8'h80, 1'b0);
      send_byte(lebd_pkg::KIND_U32, 8'h08, 1'b0);
      repeat (5) send_byte(lebd_pkg::KIND_U32, 8'h80, 1'b0);
   endtask

   task automatic test_wide_limits();
      send_byte(lebd_pkg::KIND_S64, 8'hff, 1'b0);
      repeat (8) send_byte(lebd_pkg::KIND_U32, 8'hff, 1'b0);
      send_byte(lebd_pkg::KIND_U32, 8'h7f, 1'b1);
   endtask

   task automatic test_random_stream(input int count);
      int stop_at;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) send_random_number();
   endtask

   task automatic test_unbroken_stream(input int count);
      int stop_at;
      stop_at = bytes_sent + count;
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      while (bytes_sent < stop_at) send_random_number();
      gaps_on = 1'b1;
      stalls_on = 1'b1;
   endtask

   // hold the output off long enough for the queue to fill and stall the input
   task automatic test_output_backpressure();
      hold_req = 300;
      gaps_on = 1'b0;
      repeat (40) begin
         send_byte(lebd_pkg::kind_type'($urandom_range(3)),
                   {1'b0, 7'($urandom_range(127))}, 1'b0);
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = lebd_pkg::KIND_U32;
      req_tlast = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_short_numbers();
      test_narrow_limits();
      test_wide_limits();
      test_random_stream(1100);
      test_unbroken_stream(250);
      test_output_backpressure();
      test_random_stream(60);

      while (pending_numbers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d bytes sent over all four kinds, with gaps, stalls and a long hold-off",
               bytes_sent);
      $display("%0d numbers decoded, %0d length errors, %0d sign errors, %0d mismatches",
               ok_count, length_err_count, sign_err_count, errors);
      if (errors == 0) begin
         $display("bounded_leb128_stream_decoder test passed");
      end else begin
         $display("bounded_leb128_stream_decoder test failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/lebd_pkg.sv
rtl/lebd_front.sv
rtl/lebd_fifo.sv
rtl/lebd_back.sv
rtl/bounded_leb128_stream_decoder.sv
test/bounded_leb128_stream_decoder_tb.sv
